// ===== src/trxr_pkg.sv =====
// Shared types, codes and constants of the table-lagged XOR generator.
// Holds the noise ROM, the index step rule and the queue entry type.
// No dependencies.
package trxr_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned IDX_W  = 6;
    localparam int unsigned ROM_DEPTH = 64;

    // Request codes carried on s_tuser
    typedef enum logic [1:0] {
        OP_RESEED  = 2'd0,
        OP_RAW     = 2'd1,
        OP_BOUNDED = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // Work kinds after classification in the front end
    typedef enum logic [1:0] {
        KIND_SEED    = 2'd0,
        KIND_RAW     = 2'd1,
        KIND_BOUNDED = 2'd2,
        KIND_EQUAL   = 2'd3
    } kind_t;

    // Index step-down amounts and wrap-up amounts
    localparam logic [IDX_W-1:0] STEP_FIRST  = 6'd7;
    localparam logic [IDX_W-1:0] STEP_SECOND = 6'd6;
    localparam logic [IDX_W-1:0] STEP_THIRD  = 6'd3;
    localparam logic [IDX_W-1:0] STEP_FOURTH = 6'd1;
    localparam logic [IDX_W-1:0] WRAP_FIRST  = 6'd54;
    localparam logic [IDX_W-1:0] WRAP_SECOND = 6'd53;
    localparam logic [IDX_W-1:0] WRAP_THIRD  = 6'd50;
    localparam logic [IDX_W-1:0] WRAP_FOURTH = 6'd46;

    // Seed moduli; the fourth index equals seed mod 47 since
    // seed + 17 * (seed / 47) == seed mod 47 (mod 64)
    localparam int unsigned MOD_FIRST  = 61;
    localparam int unsigned MOD_SECOND = 59;
    localparam int unsigned MOD_THIRD  = 53;
    localparam int unsigned MOD_FOURTH = 47;

    localparam logic [WORD_W-1:0] NOISE_ROM [ROM_DEPTH] = '{
        32'd2569475214, 32'd147303165,  32'd524216021,  32'd3663051766,
        32'd1783275637, 32'd4288134632, 32'd2679938014, 32'd1184991873,
        32'd1675823982, 32'd1567390326, 32'd3395933064, 32'd632899523,
        32'd1067625347, 32'd3128705446, 32'd26586341,   32'd3238645630,
        32'd1903190745, 32'd33938317,   32'd1424983844, 32'd808965318,
        32'd2076908496, 32'd3973637304, 32'd3702378057, 32'd3298076947,
        32'd229521807,  32'd249385496,  32'd2247490168, 32'd1840239192,
        32'd995340964,  32'd3192956241, 32'd301215228,  32'd4044789832,
        32'd1715330950, 32'd791561310,  32'd392890166,  32'd3058444683,
        32'd3881798114, 32'd3777079245, 32'd3982870861, 32'd597487358,
        32'd79134003,   32'd1076533918, 32'd4082831539, 32'd2451339138,
        32'd1461603872, 32'd2349232674, 32'd4218629223, 32'd3205153369,
        32'd217668729,  32'd1746016808, 32'd1108948084, 32'd4169449649,
        32'd2635460664, 32'd1866134112, 32'd2448134324, 32'd1630895901,
        32'd1443050074, 32'd2469119395, 32'd1128992640, 32'd1021356279,
        32'd644141462,  32'd1338787287, 32'd3051991240, 32'd3929134592
    };

    // One queue entry: word is the seed for a reseed and the low bound otherwise
    typedef struct packed {
        kind_t              kind;
        logic [WORD_W-1:0]  word;
        logic [WORD_W-1:0]  span;
        logic [IDX_W-1:0]   rem_first;
        logic [IDX_W-1:0]   rem_second;
        logic [IDX_W-1:0]   rem_third;
        logic [IDX_W-1:0]   rem_fourth;
    } q_item_t;

    function automatic logic [IDX_W-1:0] step_index(
        input logic [IDX_W-1:0] idx,
        input logic [IDX_W-1:0] down,
        input logic [IDX_W-1:0] wrap
    );
        if (idx >= down) begin
            return idx - down;
        end
        return idx + wrap;
    endfunction

endpackage

// ===== src/trxr_mod_lane.sv =====
// Three-stage remainder of a 32-bit word by a small constant modulus.
// Folds bytes by their weights, then divides by reciprocal multiply.
// Depends on trxr_pkg.
module trxr_mod_lane import trxr_pkg::*; #(
    parameter int unsigned MODULUS = 61
) (
    input  logic                aclk,
    input  logic                en,
    input  logic [WORD_W-1:0]   value_in,
    output logic [IDX_W-1:0]    rem_out
);

    localparam int unsigned SUM_W  = 16;
    localparam int unsigned SHIFT  = 22;
    localparam int unsigned PROD_W = 33;
    localparam int unsigned QUOT_W = PROD_W - SHIFT;
    localparam logic [SUM_W-1:0] W8  = SUM_W'(256 % MODULUS);
    localparam logic [SUM_W-1:0] W16 = SUM_W'((256 * (256 % MODULUS)) % MODULUS);
    localparam logic [SUM_W-1:0] W24 =
        SUM_W'((256 * ((256 * (256 % MODULUS)) % MODULUS)) % MODULUS);
    localparam logic [PROD_W-1:0] RECIP =
        PROD_W'(((64'd1 << SHIFT) + 64'(MODULUS) - 64'd1) / 64'(MODULUS));
    localparam logic [SUM_W-1:0] MOD_C = SUM_W'(MODULUS);

    logic [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum2_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [QUOT_W-1:0] quot;
    logic [SUM_W-1:0]  rem_next;
    logic [IDX_W-1:0]  rem_reg;

    // Byte weights are 2^(8k) mod m, so the sum keeps the remainder
    assign sum_next = {8'd0, value_in[7:0]}
                    + {8'd0, value_in[15:8]}  * W8
                    + {8'd0, value_in[23:16]} * W16
                    + {8'd0, value_in[31:24]} * W24;

    assign quot     = prod_reg[PROD_W-1:SHIFT];
    assign rem_next = sum2_reg - SUM_W'(quot) * MOD_C;

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg  <= sum_next;
            prod_reg <= PROD_W'(sum_reg) * RECIP;
            sum2_reg <= sum_reg;
            rem_reg  <= rem_next[IDX_W-1:0];
        end
    end

    assign rem_out = rem_reg;

endmodule

// ===== src/trxr_front.sv =====
// Front end: accepts requests, classifies them, forms the bounded span and
// derives the seed indices in a three-stage pipeline. Depends on trxr_pkg.
module trxr_front import trxr_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [1:0]          in_op,
    input  logic [WORD_W-1:0]   in_seed,
    input  logic [WORD_W-1:0]   in_low,
    input  logic [WORD_W-1:0]   in_high,
    output logic                out_valid,
    output q_item_t             out_item
);

    op_t              op;
    logic             lo_le_hi;
    logic [WORD_W-1:0] diff;
    q_item_t          f1_next;
    logic             f1_valid_next;
    q_item_t          f1_reg, f2_reg, f3_reg;
    logic             f1_valid_reg, f2_valid_reg, f3_valid_reg;
    logic [IDX_W-1:0] rem_first, rem_second, rem_third, rem_fourth;

    assign op       = op_t'(in_op);
    assign lo_le_hi = $signed(in_low) <= $signed(in_high);
    assign diff     = lo_le_hi ? (in_high - in_low) : (in_low - in_high);

    always_comb begin
        f1_next            = '0;
        f1_next.span       = diff + WORD_W'(1);
        f1_next.word       = in_low;
        f1_valid_next      = in_valid;
        unique case (op)
            OP_RESEED: begin
                f1_next.kind = KIND_SEED;
                f1_next.word = in_seed;
            end
            OP_RAW: begin
                f1_next.kind = KIND_RAW;
            end
            OP_BOUNDED: begin
                f1_next.kind = (in_low == in_high) ? KIND_EQUAL : KIND_BOUNDED;
            end
            default: begin
                // drop unused code
                f1_next.kind  = KIND_RAW;
                f1_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end else if (en) begin
            f1_valid_reg <= f1_valid_next;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_reg <= f1_next;
            f2_reg <= f1_reg;
            f3_reg <= f2_reg;
        end
    end

    trxr_mod_lane #(.MODULUS(MOD_FIRST)) u_lane_first (
        .aclk(aclk), .en(en), .value_in(in_seed), .rem_out(rem_first)
    );
    trxr_mod_lane #(.MODULUS(MOD_SECOND)) u_lane_second (
        .aclk(aclk), .en(en), .value_in(in_seed), .rem_out(rem_second)
    );
    trxr_mod_lane #(.MODULUS(MOD_THIRD)) u_lane_third (
        .aclk(aclk), .en(en), .value_in(in_seed), .rem_out(rem_third)
    );
    trxr_mod_lane #(.MODULUS(MOD_FOURTH)) u_lane_fourth (
        .aclk(aclk), .en(en), .value_in(in_seed), .rem_out(rem_fourth)
    );

    always_comb begin
        out_item            = f3_reg;
        out_item.rem_first  = rem_first;
        out_item.rem_second = rem_second;
        out_item.rem_third  = rem_third;
        out_item.rem_fourth = rem_fourth;
    end

    assign out_valid = f3_valid_reg;

endmodule

// ===== src/trxr_queue.sv =====
// Small FIFO of classified requests between the front and back ends.
// Depends on trxr_pkg for the entry type.
module trxr_queue import trxr_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  q_item_t push_item,
    input  logic    pop,
    output logic    not_empty,
    output logic    full,
    output q_item_t head_item
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    q_item_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item = mem[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    assign full      = count_reg == CNT_W'(DEPTH);

endmodule

// ===== src/trxr_back.sv =====
// Back end: holds generator state, runs the draw, scales bounded draws and
// drives the result register. Depends on trxr_pkg.
module trxr_back import trxr_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  q_item_t             item,
    output logic                item_pop,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [WORD_W-1:0]   res_raw,
    output logic [WORD_W-1:0]   res_bounded
);

    logic                en;
    logic                take;
    logic [WORD_W-1:0]   acc_reg;
    logic [IDX_W-1:0]    idx_first_reg, idx_second_reg, idx_third_reg, idx_fourth_reg;
    logic [IDX_W-1:0]    idx_first_next, idx_second_next, idx_third_next, idx_fourth_next;
    logic [WORD_W-1:0]   w_first, w_second, w_third, w_fourth;
    logic [WORD_W-1:0]   mix;
    logic [WORD_W-1:0]   acc_next;

    logic                b1_valid_reg, b2_valid_reg, out_valid_reg;
    logic [WORD_W-1:0]   b1_raw_reg, b1_span_reg, b1_low_reg;
    logic                b1_pass_reg;
    logic [WORD_W-1:0]   b2_raw_reg, b2_low_reg;
    logic                b2_pass_reg;
    logic [2*WORD_W-1:0] b2_prod_reg;
    logic [WORD_W-1:0]   out_raw_reg, out_bounded_reg;

    // advance the whole back end unless the result is held
    assign en       = !out_valid_reg || res_ready;
    assign take     = en && item_valid;
    assign item_pop = take;

    assign idx_first_next  = step_index(idx_first_reg,  STEP_FIRST,  WRAP_FIRST);
    assign idx_second_next = step_index(idx_second_reg, STEP_SECOND, WRAP_SECOND);
    assign idx_third_next  = step_index(idx_third_reg,  STEP_THIRD,  WRAP_THIRD);
    assign idx_fourth_next = step_index(idx_fourth_reg, STEP_FOURTH, WRAP_FOURTH);

    assign w_first  = NOISE_ROM[idx_first_next];
    assign w_second = NOISE_ROM[idx_second_next];
    assign w_third  = NOISE_ROM[idx_third_next];
    assign w_fourth = NOISE_ROM[idx_fourth_next];

    assign mix = w_first
               ^ {w_second[28:0], w_second[31:29]}
               ^ {w_third[29:0],  w_third[31:30]}
               ^ {w_fourth[30:0], w_fourth[31]};

    assign acc_next = acc_reg + mix;

    // generator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg        <= '0;
            idx_first_reg  <= '0;
            idx_second_reg <= '0;
            idx_third_reg  <= '0;
            idx_fourth_reg <= '0;
        end else if (take) begin
            unique case (item.kind)
                KIND_SEED: begin
                    acc_reg        <= item.word;
                    idx_first_reg  <= item.rem_first;
                    idx_second_reg <= item.rem_second;
                    idx_third_reg  <= item.rem_third;
                    idx_fourth_reg <= item.rem_fourth;
                end
                KIND_RAW, KIND_BOUNDED: begin
                    acc_reg        <= acc_next;
                    idx_first_reg  <= idx_first_next;
                    idx_second_reg <= idx_second_next;
                    idx_third_reg  <= idx_third_next;
                    idx_fourth_reg <= idx_fourth_next;
                end
                default: begin
                    // equal bounds leave state alone
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            b1_valid_reg  <= take && (item.kind != KIND_SEED);
            b2_valid_reg  <= b1_valid_reg;
            out_valid_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_low_reg  <= item.word;
            b1_pass_reg <= item.kind == KIND_RAW;
            unique case (item.kind)
                KIND_BOUNDED: begin
                    b1_raw_reg  <= acc_next;
                    b1_span_reg <= item.span;
                end
                KIND_RAW: begin
                    b1_raw_reg  <= acc_next;
                    b1_span_reg <= '0;
                end
                default: begin
                    // zero span yields the low bound
                    b1_raw_reg  <= '0;
                    b1_span_reg <= '0;
                end
            endcase

            b2_prod_reg <= (2*WORD_W)'(b1_span_reg) * (2*WORD_W)'(b1_raw_reg);
            b2_raw_reg  <= b1_raw_reg;
            b2_low_reg  <= b1_low_reg;
            b2_pass_reg <= b1_pass_reg;

            out_raw_reg     <= b2_raw_reg;
            out_bounded_reg <= b2_pass_reg ? b2_raw_reg
                                           : b2_low_reg + b2_prod_reg[2*WORD_W-1:WORD_W];
        end
    end

    assign res_valid   = out_valid_reg;
    assign res_raw     = out_raw_reg;
    assign res_bounded = out_bounded_reg;

endmodule

// ===== src/table_lagged_xor_rng_core.sv =====
// Table-driven lagged XOR random generator, top level.
// Instantiates front end, request queue and back end; depends on trxr_pkg.
//
// Input stream (s_): one request per word. s_tuser carries the request code:
// reseed, raw draw or bounded draw; code 3 is dropped. s_tdata carries the
// seed and the two signed bounds. A reseed loads the accumulator and the four
// ROM indices and returns nothing; each draw returns one word on m_.
// Output stream (m_): m_tdata holds the new accumulator value and the bounded
// value (a raw draw repeats the raw bits there; equal bounds give raw zero,
// the low bound, and leave the state untouched).
// Throughput: one request per cycle sustained while m_tready is high. The
// accumulator and index update loops through the state registers alone
// (four ROM reads, XOR, 32-bit add). Path from acceptance to m_tvalid: three
// front stages (seed remainders by reciprocal multiply), one queue slot,
// then state update, 32x32 scaling multiply and the output register.
// Reset (aresetn low, synchronous) clears accumulator, indices, queue and
// all valid flags. When m_tready is low the back end holds its word; the
// front end keeps accepting until the QUEUE_DEPTH-entry queue fills, and
// s_tready drops only while the queue is full.
module table_lagged_xor_rng_core import trxr_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,    // [31:0] seed_value, [63:32] low_bound, [95:64] high_bound
    input  logic [1:0]   s_tuser,    // [1:0] operation

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata     // [31:0] raw_word, [63:32] bounded_value
);

    logic    front_en;
    logic    front_valid;
    q_item_t front_item;
    logic    q_full;
    logic    q_not_empty;
    logic    q_pop;
    q_item_t q_head;
    logic [WORD_W-1:0] res_raw, res_bounded;

    assign front_en = !q_full;
    assign s_tready = front_en;

    trxr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (front_en),
        .in_valid  (s_tvalid),
        .in_op     (s_tuser),
        .in_seed   (s_tdata[31:0]),
        .in_low    (s_tdata[63:32]),
        .in_high   (s_tdata[95:64]),
        .out_valid (front_valid),
        .out_item  (front_item)
    );

    trxr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_en && front_valid),
        .push_item (front_item),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .full      (q_full),
        .head_item (q_head)
    );

    trxr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (q_not_empty),
        .item        (q_head),
        .item_pop    (q_pop),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_raw     (res_raw),
        .res_bounded (res_bounded)
    );

    assign m_tdata = {res_bounded, res_raw};

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for table_lagged_xor_rng_core: drives reseed, raw,
// bounded-draw and dropped code-3 words on s_ and checks each m_ word against
// a local generator model. Depends on trxr_pkg (request codes) and the core RTL.
module testbench;
    import trxr_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned PHASE_WORDS = 325;
    localparam int unsigned MAX_PRINTS  = 40;
    localparam logic [31:0] S_MIN = 32'h8000_0000;
    localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] ONES  = 32'hFFFF_FFFF;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;    // [31:0] seed_value, [63:32] low_bound, [95:64] high_bound
    logic [1:0]   s_tuser = OP_NONE; // [1:0] operation
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;          // [31:0] raw_word, [63:32] bounded_value

    table_lagged_xor_rng_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Noise words addressed by the four lagged indices
    localparam logic [31:0] NOISE [64] = '{
        32'd2569475214, 32'd147303165,  32'd524216021,  32'd3663051766,
        32'd1783275637, 32'd4288134632, 32'd2679938014, 32'd1184991873,
        32'd1675823982, 32'd1567390326, 32'd3395933064, 32'd632899523,
        32'd1067625347, 32'd3128705446, 32'd26586341,   32'd3238645630,
        32'd1903190745, 32'd33938317,   32'd1424983844, 32'd808965318,
        32'd2076908496, 32'd3973637304, 32'd3702378057, 32'd3298076947,
        32'd229521807,  32'd249385496,  32'd2247490168, 32'd1840239192,
        32'd995340964,  32'd3192956241, 32'd301215228,  32'd4044789832,
        32'd1715330950, 32'd791561310,  32'd392890166,  32'd3058444683,
        32'd3881798114, 32'd3777079245, 32'd3982870861, 32'd597487358,
        32'd79134003,   32'd1076533918, 32'd4082831539, 32'd2451339138,
        32'd1461603872, 32'd2349232674, 32'd4218629223, 32'd3205153369,
        32'd217668729,  32'd1746016808, 32'd1108948084, 32'd4169449649,
        32'd2635460664, 32'd1866134112, 32'd2448134324, 32'd1630895901,
        32'd1443050074, 32'd2469119395, 32'd1128992640, 32'd1021356279,
        32'd644141462,  32'd1338787287, 32'd3051991240, 32'd3929134592
    };

    typedef struct {
        logic [31:0] raw;
        logic [31:0] bounded;
    } draw_word_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] seed;
        logic [31:0] lo;
        logic [31:0] hi;
        bit          pin_raw;
        logic [31:0] raw;
        bit          pin_bnd;
        logic [31:0] bnd;
    } stim_row_t;

    // Typed-in results only where they are obvious: equal bounds, full span
    localparam int unsigned NUM_ROWS = 22;
    localparam stim_row_t DIRECTED [NUM_ROWS] = '{
        '{OP_RAW,     ONES,   ONES,         ONES,         1'b0, 32'd0, 1'b0, 32'd0},
        '{OP_RAW,     32'd0,  32'd0,        32'd0,        1'b0, 32'd0, 1'b0, 32'd0},
        '{OP_BOUNDED, 32'd0,  32'd0,        32'd0,        1'b1, 32'd0, 1'b1, 32'd0},
        '{OP_BOUNDED, ONES,   S_MAX,        S_MAX,        1'b1, 32'd0, 1'b1, S_MAX},
        '{OP_BOUNDED, 32'd0,  S_MIN,        S_MIN,        1'b1, 32'd0, 1'b1, S_MIN},
        '{OP_BOUNDED, 32'd0,  S_MIN,        S_MAX,        1'b0, 32'd0, 1'b1, S_MIN},
        '{OP_BOUNDED, 32'd0,  S_MAX,        S_MIN,        1'b0, 32'd0, 1'b1, S_MAX},
        '{OP_BOUNDED, 32'd0,  32'd0,        32'd1,        1'b0, 32'd0, 1'b0, 32'd0},
        '{OP_BOUNDED, 32'd0,  32'd5,        -32'sd5,      1'b0, 32'd0, 1'b0, 32'd0},
        '{OP_RESEED,  32'd0,  ONES,         ONES,         1'b0, 32'd0, 1'b0, 32'd0},
        '{OP_RAW,     32'd0,  32'd0,        32'd0,        1'b0, 32'd0, 1'b0, 32'd0},
        '{OP_RESEED,  ONES,   32'd0,        32'd0,        1'b0, 32'd0, 1'b0, 32'd0},
        '{OP_RAW,     32'd0,  32'd0,        32'd0,        1'b0, 32'd0, 1'b0, 32'd0},
        '{OP_BOUNDED, 32'd0,  ONES,         32'd0,        1'b0, 32'd0, 1'b0, 32'd0},
        '{OP_NONE,    ONES,   ONES,         32'd7,        1'b0, 32'd0, 1'b0, 32'd0},
        '{OP_RAW,     32'd0,  32'd0,        32'd0,        1'b0, 32'd0, 1'b0, 32'd0},
        '{OP_RESEED,  32'd47, 32'd0,        32'd0,        1'b0, 32'd0, 1'b0, 32'd0},
        '{OP_RAW,     32'd0,  32'd0,        32'd0,        1'b0, 32'd0, 1'b0, 32'd0},
        '{OP_RESEED,  S_MIN,  32'd0,        32'd0,        1'b0, 32'd0, 1'b0, 32'd0},
        '{OP_BOUNDED, 32'd0,  S_MIN,        S_MIN + 32'd1, 1'b0, 32'd0, 1'b0, 32'd0},
        '{OP_RAW,     32'd0,  32'd0,        32'd0,        1'b0, 32'd0, 1'b0, 32'd0},
        '{OP_BOUNDED, 32'd0,  ONES,         ONES,         1'b1, 32'd0, 1'b1, ONES}
    };

    // Generator model state
    logic [31:0] gen_acc;
    logic [5:0]  gen_idx_a, gen_idx_b, gen_idx_c, gen_idx_d;

    draw_word_t  pending_draws [$];
    int unsigned mismatch_count = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;

    function automatic logic [5:0] lag_step(logic [5:0] idx, logic [5:0] down,
                                            logic [5:0] wrap);
        return (idx >= down) ? idx - down : idx + wrap;
    endfunction

    function automatic logic [31:0] rol(logic [31:0] x, int unsigned k);
        return (k == 0) ? x : ((x << k) | (x >> (32 - k)));
    endfunction

    task automatic advance_generator();
        gen_idx_a = lag_step(gen_idx_a, 6'd7, 6'd54);
        gen_idx_b = lag_step(gen_idx_b, 6'd6, 6'd53);
        gen_idx_c = lag_step(gen_idx_c, 6'd3, 6'd50);
        gen_idx_d = lag_step(gen_idx_d, 6'd1, 6'd46);
        gen_acc = gen_acc + (NOISE[gen_idx_a] ^ rol(NOISE[gen_idx_b], 3)
                  ^ rol(NOISE[gen_idx_c], 2) ^ rol(NOISE[gen_idx_d], 1));
    endtask

    // Update the model for one request; has_word is set when a result follows
    task automatic predict_draw(input op_t op, input logic [31:0] seed, lo, hi,
                                output bit has_word, output draw_word_t w);
        logic [31:0] fold;
        logic [31:0] span;
        logic [63:0] prod;
        has_word = 1'b0;
        w = '{32'd0, 32'd0};
        case (op)
            OP_RESEED: begin
                fold = seed + 32'd17 * (seed / 32'd47);
                gen_acc = seed;
                gen_idx_a = 6'(seed % 32'd61);
                gen_idx_b = 6'(seed % 32'd59);
                gen_idx_c = 6'(seed % 32'd53);
                gen_idx_d = fold[5:0];
            end
            OP_RAW: begin
                advance_generator();
                has_word = 1'b1;
                w = '{gen_acc, gen_acc};
            end
            OP_BOUNDED: begin
                has_word = 1'b1;
                if (lo == hi) begin
                    w = '{32'd0, lo};
                end else begin
                    advance_generator();
                    span = (($signed(lo) <= $signed(hi)) ? hi - lo : lo - hi) + 32'd1;
                    prod = 64'(span) * 64'(gen_acc);
                    w = '{gen_acc, lo + prod[63:32]};
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t: mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Present one request word, hold until taken, then record its expectation
    task automatic send_request(input op_t op, input logic [31:0] seed, lo, hi,
                                input bit pin_raw, input logic [31:0] raw,
                                input bit pin_bnd, input logic [31:0] bnd);
        bit         has_word;
        draw_word_t w;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata <= {$urandom, $urandom, $urandom};
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {hi, lo, seed};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_draw(op, seed, lo, hi, has_word, w);
        if (pin_raw)
            w.raw = raw;
        if (pin_bnd)
            w.bounded = bnd;
        if (has_word)
            pending_draws.push_back(w);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(5))
            0: return S_MIN;
            1: return S_MAX;
            2: return ONES;
            3: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random();
        logic [31:0] seed, lo, hi;
        int unsigned pick;
        op_t op;
        pick = $urandom_range(99);
        op = (pick < 12) ? OP_RESEED : (pick < 50) ? OP_RAW :
             (pick < 95) ? OP_BOUNDED : OP_NONE;
        seed = ($urandom_range(3) == 0) ? pick_word() : $urandom;
        lo = $urandom;
        hi = $urandom;
        case ($urandom_range(4))
            0: hi = lo + $urandom_range(64) - 32'd32;
            1: begin
                lo = pick_word();
                hi = pick_word();
            end
            2: hi = lo;
            3: hi = lo ^ (32'd1 << $urandom_range(31));
            default: ;
        endcase
        send_request(op, seed, lo, hi, 1'b0, 32'd0, 1'b0, 32'd0);
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare each taken result word with the oldest expectation
    always @(posedge aclk) begin
        draw_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_draws.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", m_tdata));
            end else begin
                want = pending_draws.pop_front();
                if (m_tdata[31:0] !== want.raw)
                    report_mismatch($sformatf("raw_word %h, want %h",
                                              m_tdata[31:0], want.raw));
                if (m_tdata[63:32] !== want.bounded)
                    report_mismatch($sformatf("bounded_value %h, want %h",
                                              m_tdata[63:32], want.bounded));
            end
        end
    end

    // End the run if no word moves on either side for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        gen_acc = '0;
        gen_idx_a = '0;
        gen_idx_b = '0;
        gen_idx_c = '0;
        gen_idx_d = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i])
            send_request(DIRECTED[i].op, DIRECTED[i].seed, DIRECTED[i].lo, DIRECTED[i].hi,
                         DIRECTED[i].pin_raw, DIRECTED[i].raw,
                         DIRECTED[i].pin_bnd, DIRECTED[i].bnd);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 53; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 53; end
                default: begin idle_pct = 16; stall_pct = 16; end
            endcase
            repeat (PHASE_WORDS) send_random();
        end
        s_tvalid <= 1'b0;

        // Drain, then give the pipeline time to show any stray word
        while (pending_draws.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/trxr_pkg.sv
src/trxr_mod_lane.sv
src/trxr_front.sv
src/trxr_queue.sv
src/trxr_back.sv
src/table_lagged_xor_rng_core.sv
dv/testbench.sv
